FILE: rtl/core/acg_pkg.sv
`default_nettype none
package acg_pkg;

	// Request codes carried in req_type.
	localparam logic [3:0] REQ_ADD_MEMBER = 4'd0;
	localparam logic [3:0] REQ_DEL_MEMBER = 4'd1;
	localparam logic [3:0] REQ_MOD_MEMBER = 4'd2;
	localparam logic [3:0] REQ_NEW_GROUP  = 4'd3;
	localparam logic [3:0] REQ_DEL_GROUP  = 4'd4;
	localparam logic [3:0] REQ_GRP_ADD    = 4'd5;
	localparam logic [3:0] REQ_GRP_REMOVE = 4'd6;
	localparam logic [3:0] REQ_LOOKUP     = 4'd7;
	localparam logic [3:0] REQ_CLEAR_ALL  = 4'd8;

	// Status codes.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_ABSENT  = 3'd2;
	localparam logic [2:0] ST_NOGROUP = 3'd3;
	localparam logic [2:0] ST_ALREADY = 3'd4;
	localparam logic [2:0] ST_EMPTY   = 3'd5;

	// Bits examined per cycle by the bitmap scanner.
	localparam int CHUNK = 16;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [7:0]  member_index;
		logic [5:0]  group_index;
		logic        is_group;
		logic [31:0] hash_value;
		logic [63:0] entry_data;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  result_index;
		logic [63:0] result_data;
	} rsp_t;

endpackage
`default_nettype wire

FILE: rtl/core/action_profile_group_selector_core.sv
`default_nettype none
// Channel   Signals            Direction  Handshake
// request   start, req, busy   in         taken when start is high and busy is low
// result    done, rsp          out        one-cycle strobe on done, cannot be held off
//
// Control requests go through S_RD and S_EXEC; done is registered from S_EXEC.
// Add member and create group scan the bitmap 16 bits a cycle.
// Group lookup runs a serial modulo, then the member bitset scan and a member data read.
// Reset clears the bitmaps and the group row valid flags at once; no clearing pass.
// busy stays high from acceptance until the cycle in which done is raised.
module action_profile_group_selector_core #(
	parameter int NUM_MEMBERS = 256,
	parameter int NUM_GROUPS  = 64,
	parameter int DATA_BITS   = 64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  acg_pkg::req_t req,
	output logic        busy,
	output logic        done,
	output acg_pkg::rsp_t rsp
);
	import acg_pkg::*;

	localparam int MIDX_W = $clog2(NUM_MEMBERS);
	localparam int GIDX_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int SZW    = $clog2(NUM_MEMBERS + 1);
	localparam int RW     = SZW + NUM_MEMBERS;
	localparam int MCH    = (NUM_MEMBERS + CHUNK - 1) / CHUNK;
	localparam int GCH    = (NUM_GROUPS + CHUNK - 1) / CHUNK;
	localparam int SCH    = (MCH > GCH) ? MCH : GCH;
	localparam int SW     = SCH * CHUNK;
	localparam int CW     = (SCH > 1) ? $clog2(SCH) : 1;
	localparam int IW     = $clog2(SW);
	localparam int OFW    = $clog2(CHUNK);
	localparam int PCW    = $clog2(CHUNK + 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD   = 7'b0000010,
		S_EXEC = 7'b0000100,
		S_DIV  = 7'b0001000,
		S_SCAN = 7'b0010000,
		S_DATA = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		SM_FREE_M = 2'd0,
		SM_FREE_G = 2'd1,
		SM_NTH    = 2'd2
	} scan_mode_t;

	state_t               state_q, state_d;
	scan_mode_t           mode_q, mode_d;
	req_t                 req_q;
	logic [NUM_MEMBERS-1:0] used_q;
	logic [NUM_GROUPS-1:0]  gvalid_q;
	logic [NUM_GROUPS-1:0]  rowvld_q;
	logic [RW-1:0]        grp_mem [NUM_GROUPS];
	logic [RW-1:0]        row_q;
	logic [DATA_BITS-1:0] store [NUM_MEMBERS];
	logic [DATA_BITS-1:0] data_q;
	logic [CW-1:0]        c_q;
	logic [SZW-1:0]       k_q;
	logic [IW-1:0]        idx_q;
	logic                 done_q;
	rsp_t                 rsp_q;

	logic                 m_ok, g_in, g_ok, mbit;
	logic [MIDX_W-1:0]    maddr;
	logic [GIDX_W-1:0]    gaddr;
	logic [RW-1:0]        row_eff;
	logic [NUM_MEMBERS-1:0] row_bits;
	logic [SZW-1:0]       row_size;
	logic [SW-1:0]        scan_vec;
	logic [CHUNK-1:0]     chunk;
	logic [CW-1:0]        last_c;
	logic                 hit;
	logic [OFW-1:0]       off;
	logic [PCW-1:0]       pcount;
	logic [IW-1:0]        hit_idx;
	logic                 mod_start, mod_done;
	logic [SZW-1:0]       mod_rem;

	logic                 fin;
	logic [2:0]           fst;
	logic [IW-1:0]        fidx;
	logic [DATA_BITS-1:0] fdata;
	logic                 grp_we;
	logic [RW-1:0]        grp_wdata;
	logic                 st_we;
	logic [MIDX_W-1:0]    st_waddr, st_raddr;
	logic                 used_set, used_clr, gv_set, gv_clr, rv_set, rv_clr, clr_all;
	logic [MIDX_W-1:0]    used_idx;
	logic [GIDX_W-1:0]    gv_idx;
	logic                 scan_go;

	assign maddr    = MIDX_W'(req_q.member_index);
	assign gaddr    = GIDX_W'(req_q.group_index);
	assign m_ok     = 32'(req_q.member_index) < NUM_MEMBERS;
	assign g_in     = 32'(req_q.group_index) < NUM_GROUPS;
	assign g_ok     = g_in && gvalid_q[gaddr];
	// A group row that was never written since its group was created reads as empty.
	assign row_eff  = rowvld_q[gaddr] ? row_q : '0;
	assign row_bits = row_eff[NUM_MEMBERS-1:0];
	assign row_size = row_eff[RW-1 -: SZW];
	assign mbit     = row_bits[maddr];

	always_comb begin
		scan_vec = '0;
		last_c   = CW'(MCH - 1);
		case (mode_q)
			SM_FREE_M: scan_vec[NUM_MEMBERS-1:0] = ~used_q;
			SM_FREE_G: begin
				scan_vec[NUM_GROUPS-1:0] = ~gvalid_q;
				last_c = CW'(GCH - 1);
			end
			SM_NTH:    scan_vec[NUM_MEMBERS-1:0] = row_bits;
			default:   scan_vec = '0;
		endcase
		chunk = scan_vec[c_q*CHUNK +: CHUNK];
	end

	acg_pick #(.W(CHUNK), .KW(SZW)) u_pick (
		.bits  (chunk),
		.k     ((mode_q == SM_NTH) ? k_q : '0),
		.hit   (hit),
		.off   (off),
		.count (pcount)
	);

	assign hit_idx = IW'({c_q, off});

	acg_modulo #(.DW(SZW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (req_q.hash_value),
		.divisor  (row_size),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		fin       = 1'b0;
		fst       = ST_OK;
		fidx      = '0;
		fdata     = '0;
		grp_we    = 1'b0;
		grp_wdata = row_eff;
		st_we     = 1'b0;
		st_waddr  = maddr;
		st_raddr  = (state_q == S_DATA) ? MIDX_W'(idx_q) : maddr;
		mod_start = 1'b0;
		used_set  = 1'b0;
		used_clr  = 1'b0;
		used_idx  = maddr;
		gv_set    = 1'b0;
		gv_clr    = 1'b0;
		rv_set    = 1'b0;
		rv_clr    = 1'b0;
		gv_idx    = gaddr;
		clr_all   = 1'b0;
		scan_go   = 1'b0;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_RD;
			S_RD:   state_d = S_EXEC;
			S_EXEC: begin
				state_d = S_IDLE;
				fin     = 1'b1;
				unique case (req_q.req_type)
					REQ_ADD_MEMBER: begin
						fin     = 1'b0;
						state_d = S_SCAN;
						mode_d  = SM_FREE_M;
						scan_go = 1'b1;
					end
					REQ_DEL_MEMBER: begin
						if (m_ok && used_q[maddr]) used_clr = 1'b1;
						else fst = ST_ABSENT;
					end
					REQ_MOD_MEMBER: begin
						if (m_ok && used_q[maddr]) st_we = 1'b1;
						else fst = ST_ABSENT;
					end
					REQ_NEW_GROUP: begin
						fin     = 1'b0;
						state_d = S_SCAN;
						mode_d  = SM_FREE_G;
						scan_go = 1'b1;
					end
					REQ_DEL_GROUP: begin
						if (g_ok) begin
							gv_clr = 1'b1;
							rv_clr = 1'b1;
						end else begin
							fst = ST_NOGROUP;
						end
					end
					REQ_GRP_ADD: begin
						if (!g_ok) fst = ST_NOGROUP;
						else if (!m_ok) fst = ST_ABSENT;
						else if (mbit) fst = ST_ALREADY;
						else begin
							grp_we = 1'b1;
							rv_set = 1'b1;
							grp_wdata[maddr] = 1'b1;
							grp_wdata[RW-1 -: SZW] = row_size + SZW'(1);
						end
					end
					REQ_GRP_REMOVE: begin
						if (!g_ok) fst = ST_NOGROUP;
						else if (!m_ok || !mbit) fst = ST_ABSENT;
						else begin
							grp_we = 1'b1;
							rv_set = 1'b1;
							grp_wdata[maddr] = 1'b0;
							grp_wdata[RW-1 -: SZW] = row_size - SZW'(1);
						end
					end
					REQ_LOOKUP: begin
						if (!req_q.is_group) begin
							if (m_ok) begin
								fidx  = IW'(maddr);
								fdata = data_q;
							end else begin
								fst = ST_ABSENT;
							end
						end else if (!g_ok) begin
							fst = ST_NOGROUP;
						end else if (row_size == '0) begin
							fst = ST_EMPTY;
						end else begin
							fin       = 1'b0;
							mod_start = 1'b1;
							state_d   = S_DIV;
						end
					end
					REQ_CLEAR_ALL: clr_all = 1'b1;
					default: ;
				endcase
			end
			S_DIV: begin
				if (mod_done) begin
					state_d = S_SCAN;
					mode_d  = SM_NTH;
					scan_go = 1'b1;
				end
			end
			S_SCAN: begin
				if (hit) begin
					case (mode_q)
						SM_FREE_M: begin
							used_set = 1'b1;
							used_idx = MIDX_W'(hit_idx);
							st_we    = 1'b1;
							st_waddr = MIDX_W'(hit_idx);
							fin      = 1'b1;
							fidx     = hit_idx;
							state_d  = S_IDLE;
						end
						SM_FREE_G: begin
							gv_set  = 1'b1;
							rv_clr  = 1'b1;
							gv_idx  = GIDX_W'(hit_idx);
							fin     = 1'b1;
							fidx    = hit_idx;
							state_d = S_IDLE;
						end
						default: state_d = S_DATA;
					endcase
				end else if (c_q == last_c) begin
					fin     = 1'b1;
					fst     = (mode_q == SM_NTH) ? ST_EMPTY : ST_FULL;
					state_d = S_IDLE;
				end
			end
			S_DATA: state_d = S_FIN;
			S_FIN: begin
				fin     = 1'b1;
				fidx    = idx_q;
				fdata   = data_q;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mode_q   <= SM_FREE_M;
			used_q   <= '0;
			gvalid_q <= '0;
			rowvld_q <= '0;
			done_q   <= 1'b0;
			c_q      <= '0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			done_q  <= fin;
			if (scan_go) c_q <= '0;
			else if (state_q == S_SCAN && !hit) c_q <= c_q + CW'(1);
			if (clr_all) begin
				used_q   <= '0;
				gvalid_q <= '0;
				rowvld_q <= '0;
			end else begin
				if (used_set) used_q[used_idx] <= 1'b1;
				if (used_clr) used_q[used_idx] <= 1'b0;
				if (gv_set) gvalid_q[gv_idx] <= 1'b1;
				if (gv_clr) gvalid_q[gv_idx] <= 1'b0;
				if (rv_set) rowvld_q[gv_idx] <= 1'b1;
				if (rv_clr) rowvld_q[gv_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) req_q <= req;
		if (scan_go) k_q <= (mode_d == SM_NTH) ? mod_rem : '0;
		else if (state_q == S_SCAN && !hit && mode_q == SM_NTH) k_q <= k_q - SZW'(pcount);
		if (state_q == S_SCAN && hit) idx_q <= hit_idx;
		if (fin) begin
			rsp_q.status       <= fst;
			rsp_q.result_index <= (fst == ST_OK) ? 8'(fidx) : 8'd0;
			rsp_q.result_data  <= (fst == ST_OK) ? 64'(fdata) : 64'd0;
		end
	end

	// Group bitset memory: one row per group, count in the top bits.
	always_ff @(posedge clk) begin
		if (grp_we) grp_mem[gaddr] <= grp_wdata;
		row_q <= grp_mem[gaddr];
	end

	// Member action data memory.
	always_ff @(posedge clk) begin
		if (st_we) store[st_waddr] <= DATA_BITS'(req_q.entry_data);
		data_q <= store[st_raddr];
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");
	a_err_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.result_index == 8'd0 && rsp.result_data == 64'd0)
		else $error("error result carries nonzero fields");
	a_mod_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> state_q == S_DIV)
		else $error("modulo finished outside the divide state");
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");
endmodule
`default_nettype wire

FILE: rtl/core/acg_modulo.sv
`default_nettype none
module acg_modulo #(
	parameter int DW = 9
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [31:0]   dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [DW-1:0]      rem
);
	localparam int STEPS = 32;

	logic [31:0]   dvd_q;
	logic [DW-1:0] dsr_q;
	logic [DW-1:0] rem_q;
	logic [4:0]    cnt_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          ge;
	logic [DW-1:0] nxt;

	// Restoring division, one quotient bit per cycle; only the remainder is kept.
	always_comb begin
		trial = {rem_q, dvd_q[31]};
		ge    = trial >= {1'b0, dsr_q};
		nxt   = ge ? DW'(trial - {1'b0, dsr_q}) : DW'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == 5'(STEPS - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(STEPS - 1)) run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

FILE: rtl/core/acg_pick.sv
`default_nettype none
module acg_pick #(
	parameter int W  = 16,
	parameter int KW = 9
) (
	input  wire logic [W-1:0]         bits,
	input  wire logic [KW-1:0]        k,
	output logic                      hit,
	output logic [$clog2(W)-1:0]      off,
	output logic [$clog2(W+1)-1:0]    count
);
	localparam int PCW = $clog2(W + 1);
	localparam int XW  = (KW > PCW) ? KW : PCW;

	logic [XW-1:0] cnt;

	// Finds the set bit whose rank among the set bits of the slice equals k.
	always_comb begin
		cnt = '0;
		hit = 1'b0;
		off = '0;
		for (int i = 0; i < W; i++) begin
			if (bits[i]) begin
				if (!hit && cnt == XW'(k)) begin
					hit = 1'b1;
					off = ($clog2(W))'(i);
				end
				cnt = cnt + XW'(1);
			end
		end
		count = PCW'(cnt);
	end
endmodule
`default_nettype wire
